// File: src/shape_coverage_blend_unit_assert.svh
// Assertion macros shared by the shape coverage blend unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef SHAPE_COVERAGE_BLEND_UNIT_ASSERT_SVH
`define SHAPE_COVERAGE_BLEND_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scb: next-cycle check failed");

`endif

// File: src/scb_pkg.sv
// Types, constants and the box coverage function of the shape coverage blend unit.
// Depends on nothing; used by every other file of the block but the assertion header.
package scb_pkg;

	localparam int PIX_COORD_W = 12;
	localparam int COLOR_W     = 24;
	localparam int FILL_W      = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int ORG_W       = 13;
	localparam int SIZE_W      = 12;
	localparam int RAD_W       = 11;
	localparam int COORD_W     = 15;
	localparam int DELTA_W     = 12;
	localparam int RSQ_W       = 22;
	localparam int CH_W        = 8;
	localparam int CH_N        = 3;
	localparam int SUM_W       = 16;
	localparam int DIV_PROD_W  = 33;
	localparam int DIV255_SHIFT = 23;

	localparam logic [CH_W-1:0] COLOR_MAX  = 8'hFF;
	localparam logic [16:0]     DIV255_MUL = 17'd32897;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SHAPE_MODE  = 3'd0,
		REG_RECT_X      = 3'd1,
		REG_RECT_Y      = 3'd2,
		REG_RECT_W      = 3'd3,
		REG_RECT_H      = 3'd4,
		REG_CORNER_RAD  = 3'd5,
		REG_STROKE      = 3'd6,
		REG_FILL_COLOR  = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_RECT   = 2'd0,
		MODE_ROUND  = 2'd1,
		MODE_STROKE = 2'd2,
		MODE_CIRCLE = 2'd3
	} shape_mode_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic               in_box;
		logic               sure;
		logic [DELTA_W-1:0] dx;
		logic [DELTA_W-1:0] dy;
	} box_t;

	typedef struct packed {
		shape_mode_t        mode;
		logic [ORG_W-1:0]   org_x;
		logic [ORG_W-1:0]   org_y;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
		logic [SIZE_W-1:0]  t;
		logic [SIZE_W-1:0]  iw;
		logic [SIZE_W-1:0]  ih;
		logic [RAD_W-1:0]   ro;
		logic [RAD_W-1:0]   ir;
		logic [RSQ_W-1:0]   ro_sq;
		logic [RSQ_W-1:0]   ir_sq;
		logic [RSQ_W-1:0]   c_sq;
		logic               empty;
		logic               thin;
		logic               circ_zero;
		logic [FILL_W-1:0]  fill;
	} geom_cfg_t;

	// Inside test and corner offsets of a rounded box with its origin at zero.
	function automatic box_t box_test(coord_t lx, coord_t ly, logic [SIZE_W-1:0] w,
			logic [SIZE_W-1:0] h, logic [RAD_W-1:0] r);
		coord_t wc;
		coord_t hc;
		coord_t rc;
		coord_t wr;
		coord_t hr;
		coord_t ccx;
		coord_t ccy;
		coord_t ddx;
		coord_t ddy;
		box_t   b;
		wc = coord_t'({3'b000, w});
		hc = coord_t'({3'b000, h});
		rc = coord_t'({4'b0000, r});
		wr = wc - rc;
		hr = hc - rc;
		b.in_box = (lx >= coord_t'(0)) && (ly >= coord_t'(0)) && (lx < wc) && (ly < hc);
		b.sure = b.in_box && ((r == '0) || ((lx >= rc) && (lx < wr)) ||
			((ly >= rc) && (ly < hr)));
		ccx = (lx < rc) ? (rc - coord_t'(1)) : wr;
		ccy = (ly < rc) ? (rc - coord_t'(1)) : hr;
		ddx = lx - ccx;
		ddy = ly - ccy;
		b.dx = ddx[DELTA_W-1:0];
		b.dy = ddy[DELTA_W-1:0];
		return b;
	endfunction

endpackage

// File: src/scb_if.sv
// Handshake interfaces of the shape coverage blend unit: pixel, result and config write.
// Depends on scb_pkg for the field widths.
interface scb_pix_if import scb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [PIX_COORD_W-1:0] pixel_x;
	logic [PIX_COORD_W-1:0] pixel_y;
	logic [COLOR_W-1:0]     dest_pixel;

	modport source (output valid, output pixel_x, output pixel_y, output dest_pixel,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input dest_pixel,
		output ready);
endinterface

interface scb_res_if import scb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [COLOR_W-1:0] new_pixel;

	modport source (output valid, output write_enable, output new_pixel, input ready);
	modport sink (input valid, input write_enable, input new_pixel, output ready);
endinterface

interface scb_cfg_if import scb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/scb_cfg.sv
// Configuration registers and the registered shape values derived from them.
// Depends on scb_pkg and the scb_cfg_if interface.
module scb_cfg import scb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	scb_cfg_if.sink   cfg,
	output geom_cfg_t gcfg
);

	shape_mode_t        mode_q;
	logic [ORG_W-1:0]   org_x_q;
	logic [ORG_W-1:0]   org_y_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;
	logic [RAD_W-1:0]   rad_q;
	logic [SIZE_W-1:0]  thick_q;
	logic [FILL_W-1:0]  fill_q;
	geom_cfg_t          gcfg_q;
	geom_cfg_t          gcfg_d;

	logic [SIZE_W-1:0]        mn;
	logic [RAD_W-1:0]         half;
	logic [RAD_W-1:0]         r;
	logic [SIZE_W-1:0]        t;
	logic signed [SIZE_W+1:0] iw_full;
	logic signed [SIZE_W+1:0] ih_full;
	logic signed [SIZE_W:0]   ir_full;
	logic [RAD_W-1:0]         ir;
	logic [RAD_W-1:0]         ro;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RECT;
			org_x_q <= '0;
			org_y_q <= '0;
			w_q     <= '0;
			h_q     <= '0;
			rad_q   <= '0;
			thick_q <= '0;
			fill_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_SHAPE_MODE: mode_q  <= shape_mode_t'(cfg.data[1:0]);
				REG_RECT_X:     org_x_q <= cfg.data[ORG_W-1:0];
				REG_RECT_Y:     org_y_q <= cfg.data[ORG_W-1:0];
				REG_RECT_W:     w_q     <= cfg.data[SIZE_W-1:0];
				REG_RECT_H:     h_q     <= cfg.data[SIZE_W-1:0];
				REG_CORNER_RAD: rad_q   <= cfg.data[RAD_W-1:0];
				REG_STROKE:     thick_q <= cfg.data[SIZE_W-1:0];
				REG_FILL_COLOR: fill_q  <= cfg.data[FILL_W-1:0];
			endcase
		end
	end

	always_comb begin
		mn   = (w_q < h_q) ? w_q : h_q;
		half = mn[SIZE_W-1:1];
		r    = (rad_q > half) ? half : rad_q;
		priority if (thick_q == '0) begin
			t = SIZE_W'(1);
		end else if (thick_q > mn) begin
			t = mn;
		end else begin
			t = thick_q;
		end
		iw_full = $signed({2'b00, w_q}) - $signed({1'b0, t, 1'b0});
		ih_full = $signed({2'b00, h_q}) - $signed({1'b0, t, 1'b0});
		ir_full = $signed({2'b00, r}) - $signed({1'b0, t});
		ir      = ir_full[SIZE_W] ? '0 : ir_full[RAD_W-1:0];
		ro      = (mode_q == MODE_RECT) ? '0 : r;

		gcfg_d.mode      = mode_q;
		gcfg_d.org_x     = org_x_q;
		gcfg_d.org_y     = org_y_q;
		gcfg_d.w         = w_q;
		gcfg_d.h         = h_q;
		gcfg_d.t         = t;
		gcfg_d.iw        = iw_full[SIZE_W-1:0];
		gcfg_d.ih        = ih_full[SIZE_W-1:0];
		gcfg_d.ro        = ro;
		gcfg_d.ir        = ir;
		gcfg_d.ro_sq     = RSQ_W'(ro) * RSQ_W'(ro);
		gcfg_d.ir_sq     = RSQ_W'(ir) * RSQ_W'(ir);
		gcfg_d.c_sq      = RSQ_W'(rad_q) * RSQ_W'(rad_q);
		gcfg_d.empty     = (w_q == '0) || (h_q == '0);
		gcfg_d.thin      = (iw_full <= 0) || (ih_full <= 0);
		gcfg_d.circ_zero = (rad_q == '0);
		gcfg_d.fill      = fill_q;
	end

	always_ff @(posedge clk) begin
		gcfg_q <= gcfg_d;
	end

	assign gcfg = gcfg_q;

endmodule

// File: src/scb_geom.sv
// Four-stage coverage pipeline: local offsets, box tests, squares, radius compares.
// Depends on scb_pkg for the box function and the derived shape values.
module scb_geom import scb_pkg::*; #(
	parameter int FRAME_WIDTH  = 1024,
	parameter int FRAME_HEIGHT = 1024
) (
	input  logic                   clk,
	input  logic [3:0]             stage_en,
	input  logic [PIX_COORD_W-1:0] pixel_x,
	input  logic [PIX_COORD_W-1:0] pixel_y,
	input  geom_cfg_t              gcfg,
	output logic                   covered
);

	localparam int FRAME_CMP_W = PIX_COORD_W + 1;
	localparam int OSQ_W = 2 * COORD_W - 1;
	localparam int ISQ_W = 2 * DELTA_W - 1;

	logic [PIX_COORD_W-1:0] px_s1;
	logic [PIX_COORD_W-1:0] py_s1;

	coord_t lx;
	coord_t ly;
	logic   inframe;

	coord_t lx_s2;
	coord_t ly_s2;
	coord_t lxi_s2;
	coord_t lyi_s2;
	logic   inframe_s2;

	box_t   ob;
	box_t   ib;
	coord_t ox;
	coord_t oy;

	coord_t                    ox_s3;
	coord_t                    oy_s3;
	logic signed [DELTA_W-1:0] ix_s3;
	logic signed [DELTA_W-1:0] iy_s3;
	logic                      o_in_s3;
	logic                      o_sure_s3;
	logic                      i_in_s3;
	logic                      i_sure_s3;
	logic                      inframe_s3;

	logic signed [2*COORD_W-1:0] osx;
	logic signed [2*COORD_W-1:0] osy;
	logic signed [2*DELTA_W-1:0] isx;
	logic signed [2*DELTA_W-1:0] isy;

	logic [OSQ_W-1:0] osqx_s4;
	logic [OSQ_W-1:0] osqy_s4;
	logic [ISQ_W-1:0] isqx_s4;
	logic [ISQ_W-1:0] isqy_s4;
	logic             o_in_s4;
	logic             o_sure_s4;
	logic             i_in_s4;
	logic             i_sure_s4;
	logic             inframe_s4;

	logic [OSQ_W:0] osum;
	logic [ISQ_W:0] isum;
	logic           o_hit;
	logic           i_hit;
	logic           c_hit;
	logic           shape_hit;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
		end
	end

	always_comb begin
		lx = coord_t'({3'b000, px_s1}) - coord_t'($signed(gcfg.org_x));
		ly = coord_t'({3'b000, py_s1}) - coord_t'($signed(gcfg.org_y));
		inframe = ({1'b0, px_s1} < FRAME_CMP_W'(FRAME_WIDTH)) &&
			({1'b0, py_s1} < FRAME_CMP_W'(FRAME_HEIGHT));
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			lx_s2      <= lx;
			ly_s2      <= ly;
			lxi_s2     <= lx - coord_t'({3'b000, gcfg.t});
			lyi_s2     <= ly - coord_t'({3'b000, gcfg.t});
			inframe_s2 <= inframe;
		end
	end

	always_comb begin
		ob = box_test(lx_s2, ly_s2, gcfg.w, gcfg.h, gcfg.ro);
		ib = box_test(lxi_s2, lyi_s2, gcfg.iw, gcfg.ih, gcfg.ir);
		if (gcfg.mode == MODE_CIRCLE) begin
			ox = lx_s2;
			oy = ly_s2;
		end else begin
			ox = coord_t'($signed(ob.dx));
			oy = coord_t'($signed(ob.dy));
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			ox_s3      <= ox;
			oy_s3      <= oy;
			ix_s3      <= $signed(ib.dx);
			iy_s3      <= $signed(ib.dy);
			o_in_s3    <= ob.in_box;
			o_sure_s3  <= ob.sure;
			i_in_s3    <= ib.in_box;
			i_sure_s3  <= ib.sure;
			inframe_s3 <= inframe_s2;
		end
	end

	always_comb begin
		osx = ox_s3 * ox_s3;
		osy = oy_s3 * oy_s3;
		isx = ix_s3 * ix_s3;
		isy = iy_s3 * iy_s3;
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			osqx_s4    <= osx[OSQ_W-1:0];
			osqy_s4    <= osy[OSQ_W-1:0];
			isqx_s4    <= isx[ISQ_W-1:0];
			isqy_s4    <= isy[ISQ_W-1:0];
			o_in_s4    <= o_in_s3;
			o_sure_s4  <= o_sure_s3;
			i_in_s4    <= i_in_s3;
			i_sure_s4  <= i_sure_s3;
			inframe_s4 <= inframe_s3;
		end
	end

	always_comb begin
		osum  = (OSQ_W + 1)'(osqx_s4) + (OSQ_W + 1)'(osqy_s4);
		isum  = (ISQ_W + 1)'(isqx_s4) + (ISQ_W + 1)'(isqy_s4);
		o_hit = o_in_s4 && (o_sure_s4 || (osum <= (OSQ_W + 1)'(gcfg.ro_sq)));
		i_hit = i_in_s4 && (i_sure_s4 || (isum <= (ISQ_W + 1)'(gcfg.ir_sq)));
		c_hit = !gcfg.circ_zero && (osum <= (OSQ_W + 1)'(gcfg.c_sq));
		unique case (gcfg.mode)
			MODE_RECT:   shape_hit = !gcfg.empty && o_in_s4;
			MODE_ROUND:  shape_hit = !gcfg.empty && o_hit;
			MODE_STROKE: shape_hit = !gcfg.empty && o_hit && (gcfg.thin || !i_hit);
			MODE_CIRCLE: shape_hit = c_hit;
		endcase
		covered = inframe_s4 && shape_hit;
	end

endmodule

// File: src/scb_blend.sv
// Blend datapath: per-channel weighted sum, division by 255 through a reciprocal, and delay.
// Depends on scb_pkg for the color constants.
module scb_blend import scb_pkg::*; (
	input  logic               clk,
	input  logic [3:0]         stage_en,
	input  logic [COLOR_W-1:0] dest_pixel,
	input  logic [FILL_W-1:0]  fill,
	output logic [COLOR_W-1:0] blended_s4,
	output logic [COLOR_W-1:0] dest_s4
);

	logic [COLOR_W-1:0] dest_s1;
	logic [COLOR_W-1:0] dest_s2;
	logic [COLOR_W-1:0] dest_s3;

	logic [CH_W-1:0]                 alpha;
	logic [CH_W-1:0]                 inv;
	logic [CH_N-1:0][SUM_W-1:0]      sum;
	logic [CH_N-1:0][SUM_W-1:0]      sum_s2;
	logic [CH_N-1:0][DIV_PROD_W-1:0] prod;
	logic [COLOR_W-1:0]              quo;
	logic [COLOR_W-1:0]              quo_s3;

	assign alpha = fill[FILL_W-1 -: CH_W];
	assign inv   = COLOR_MAX - alpha;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			dest_s1 <= dest_pixel;
		end
	end

	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			sum[ch] = SUM_W'(fill[ch*CH_W +: CH_W]) * SUM_W'(alpha) +
				SUM_W'(dest_s1[ch*CH_W +: CH_W]) * SUM_W'(inv);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			sum_s2  <= sum;
			dest_s2 <= dest_s1;
		end
	end

	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			prod[ch] = DIV_PROD_W'(sum_s2[ch]) * DIV_PROD_W'(DIV255_MUL);
			quo[ch*CH_W +: CH_W] = prod[ch][DIV255_SHIFT +: CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			quo_s3  <= quo;
			dest_s3 <= dest_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			blended_s4 <= quo_s3;
			dest_s4    <= dest_s3;
		end
	end

endmodule

// File: src/shape_coverage_blend_unit.sv
// Shape coverage and source-over blend, one pixel item per clock while the result side is ready.
// Five register stages, s1 through s5; the result of an item is held in the s5 register.
// Throughput is one item per cycle while the result side is ready; every stage keeps a valid bit, so bubbles close up.
// A configuration write reaches all stages at once through registered derived values, also items already in flight.
// Reset clears all configuration registers to zero and empties the pipeline.
`include "shape_coverage_blend_unit_assert.svh"
module shape_coverage_blend_unit import scb_pkg::*; #(
	parameter int FRAME_WIDTH  = 1024,
	parameter int FRAME_HEIGHT = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	scb_pix_if.sink  pixel,
	scb_res_if.source result,
	scb_cfg_if.sink  cfg
);

	geom_cfg_t gcfg;
	logic [4:0] stage_en;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic covered;
	logic [COLOR_W-1:0] blended_s4;
	logic [COLOR_W-1:0] dest_s4;
	logic [CH_W-1:0]    alpha;
	logic               we;
	logic               we_s5;
	logic [COLOR_W-1:0] pix_s5;

	scb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.gcfg   (gcfg)
	);

	scb_geom #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_geom (
		.clk      (clk),
		.stage_en (stage_en[3:0]),
		.pixel_x  (pixel.pixel_x),
		.pixel_y  (pixel.pixel_y),
		.gcfg     (gcfg),
		.covered  (covered)
	);

	scb_blend u_blend (
		.clk        (clk),
		.stage_en   (stage_en[3:0]),
		.dest_pixel (pixel.dest_pixel),
		.fill       (gcfg.fill),
		.blended_s4 (blended_s4),
		.dest_s4    (dest_s4)
	);

	assign stage_en[4] = !v_s5 || result.ready;
	assign stage_en[3] = !v_s4 || stage_en[4];
	assign stage_en[2] = !v_s3 || stage_en[3];
	assign stage_en[1] = !v_s2 || stage_en[2];
	assign stage_en[0] = !v_s1 || stage_en[1];
	assign pixel.ready = stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (stage_en[0]) v_s1 <= pixel.valid;
			if (stage_en[1]) v_s2 <= v_s1;
			if (stage_en[2]) v_s3 <= v_s2;
			if (stage_en[3]) v_s4 <= v_s3;
			if (stage_en[4]) v_s5 <= v_s4;
		end
	end

	assign alpha = gcfg.fill[FILL_W-1 -: CH_W];
	assign we    = covered && (alpha != '0);

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			we_s5 <= we;
			if (!we) begin
				pix_s5 <= dest_s4;
			end else if (alpha == COLOR_MAX) begin
				pix_s5 <= gcfg.fill[COLOR_W-1:0];
			end else begin
				pix_s5 <= blended_s4;
			end
		end
	end

	assign result.valid        = v_s5;
	assign result.write_enable = we_s5;
	assign result.new_pixel    = pix_s5;

	`SCB_ASSERT_IMP(a_bubble_ready, clk, arst_n, !v_s1, pixel.ready)
	`SCB_ASSERT_NXT(a_accept_load, clk, arst_n, pixel.valid && pixel.ready, v_s1)
	`SCB_ASSERT_NXT(a_stall_hold, clk, arst_n, v_s4 && !stage_en[3], v_s4 && v_s5)

endmodule

// File: tb/tb_shape_coverage_blend_unit.sv
// Testbench for shape_coverage_blend_unit: pixel items are checked for coverage and blending
// against a predictor kept in step with every configuration write. Depends on scb_pkg, the
// handshake interfaces in scb_if.sv and the unit itself.
module tb_shape_coverage_blend_unit;
	import scb_pkg::*;

	localparam int FRAME_W         = 1024;
	localparam int FRAME_H         = 1024;
	localparam int WATCHDOG_CYCLES = 1000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int PHASES          = 24;
	localparam int PHASE_ITEMS     = 76;

	typedef struct packed {
		logic [PIX_COORD_W-1:0] x;
		logic [PIX_COORD_W-1:0] y;
		logic [COLOR_W-1:0]     dest;
	} pix_item_t;

	typedef struct packed {
		logic               we;
		logic [COLOR_W-1:0] pix;
	} shade_t;

	typedef struct {
		shape_mode_t       mode;
		int                x;
		int                y;
		int                w;
		int                h;
		int                rad;
		int                thick;
		logic [FILL_W-1:0] fill;
	} shape_regs_t;

	logic clk = 1'b0;
	logic arst_n;

	scb_pix_if pix ();
	scb_res_if res ();
	scb_cfg_if cfg ();

	shape_coverage_blend_unit #(
		.FRAME_WIDTH (FRAME_W),
		.FRAME_HEIGHT(FRAME_H)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pixel (pix),
		.result(res),
		.cfg   (cfg)
	);

	shape_regs_t shape;
	pix_item_t   pixel_queue[$];
	shade_t      expected_writes[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          src_idle_pct = 30;
	int          sink_stall_pct = 30;
	int          src_gap = 0;
	int          sink_gap = 0;
	bit          quiet = 1'b0;
	bit          pix_fire = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit in_rounded_box(int lx, int ly, int w, int h, int r);
		int    cx;
		int    cy;
		longint dx;
		longint dy;
		if (lx < 0 || ly < 0 || lx >= w || ly >= h)
			return 1'b0;
		if (r <= 0)
			return 1'b1;
		if (lx >= r && lx < w - r)
			return 1'b1;
		if (ly >= r && ly < h - r)
			return 1'b1;
		cx = (lx < r) ? r - 1 : w - r;
		cy = (ly < r) ? r - 1 : h - r;
		dx = lx - cx;
		dy = ly - cy;
		return dx * dx + dy * dy <= longint'(r) * r;
	endfunction

	function automatic bit shape_covers(int px, int py);
		int     lx;
		int     ly;
		int     r;
		int     t;
		int     lim;
		int     iw;
		int     ih;
		int     ir;
		longint dx;
		longint dy;
		lx = px - shape.x;
		ly = py - shape.y;
		if (shape.mode == MODE_CIRCLE) begin
			dx = lx;
			dy = ly;
			return shape.rad > 0 && dx * dx + dy * dy <= longint'(shape.rad) * shape.rad;
		end
		if (shape.w <= 0 || shape.h <= 0)
			return 1'b0;
		if (shape.mode == MODE_RECT)
			return in_rounded_box(lx, ly, shape.w, shape.h, 0);
		lim = (shape.w < shape.h) ? shape.w : shape.h;
		r = (shape.rad > lim / 2) ? lim / 2 : shape.rad;
		if (shape.mode == MODE_ROUND)
			return in_rounded_box(lx, ly, shape.w, shape.h, r);
		t = (shape.thick < 1) ? 1 : ((shape.thick > lim) ? lim : shape.thick);
		iw = shape.w - 2 * t;
		ih = shape.h - 2 * t;
		if (iw <= 0 || ih <= 0)
			return in_rounded_box(lx, ly, shape.w, shape.h, r);
		ir = (r - t < 0) ? 0 : r - t;
		return in_rounded_box(lx, ly, shape.w, shape.h, r) &&
			!in_rounded_box(lx - t, ly - t, iw, ih, ir);
	endfunction

	function automatic shade_t shade_pixel(int px, int py, logic [COLOR_W-1:0] dest);
		shade_t o;
		int     a;
		int     s;
		int     d;
		o.we = 1'b0;
		o.pix = dest;
		a = shape.fill[31:24];
		if (px < FRAME_W && py < FRAME_H && a != 0 && shape_covers(px, py)) begin
			o.we = 1'b1;
			if (a == COLOR_MAX) begin
				o.pix = shape.fill[COLOR_W-1:0];
			end else begin
				for (int c = 0; c < CH_N; c++) begin
					s = shape.fill[CH_W*c +: CH_W];
					d = dest[CH_W*c +: CH_W];
					o.pix[CH_W*c +: CH_W] = CH_W'((s * a + d * (COLOR_MAX - a)) / COLOR_MAX);
				end
			end
		end
		return o;
	endfunction

	function automatic int idle_pick();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return 15;
			2: return 40;
			default: return 70;
		endcase
	endfunction

	// Pixel source.
	always @(negedge clk) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.pixel_x <= '0;
			pix.pixel_y <= '0;
			pix.dest_pixel <= '0;
			src_gap = 0;
		end else if (!(pix.valid && !pix_fire)) begin
			if (src_gap > 0) begin
				src_gap--;
				pix.valid <= 1'b0;
			end else if (pixel_queue.size() == 0) begin
				pix.valid <= 1'b0;
			end else if (!quiet && $urandom_range(99, 0) < src_idle_pct) begin
				src_gap = $urandom_range(3, 0);
				pix.valid <= 1'b0;
			end else begin
				pix.valid <= 1'b1;
				pix.pixel_x <= pixel_queue[0].x;
				pix.pixel_y <= pixel_queue[0].y;
				pix.dest_pixel <= pixel_queue[0].dest;
			end
		end
	end

	// Result sink.
	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			sink_gap = 0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			res.ready <= 1'b0;
		end else if (!quiet && $urandom_range(99, 0) < sink_stall_pct) begin
			sink_gap = $urandom_range(3, 0);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		bit     res_fire;
		bit     cfg_fire;
		shade_t want;
		if (!arst_n) begin
			pix_fire = 1'b0;
			idle_cycles = 0;
		end else begin
			pix_fire = pix.valid && pix.ready;
			res_fire = res.valid && res.ready;
			cfg_fire = cfg.valid && cfg.ready;
			if (pix_fire) begin
				expected_writes.push_back(shade_pixel(pix.pixel_x, pix.pixel_y, pix.dest_pixel));
				void'(pixel_queue.pop_front());
			end
			if (res_fire) begin
				if (expected_writes.size() == 0) begin
					$error("result item with no pixel pending: write_enable %0d new_pixel %06h",
						res.write_enable, res.new_pixel);
					mismatches++;
				end else begin
					want = expected_writes.pop_front();
					if (res.write_enable !== want.we) begin
						$error("write_enable: expected %0d, got %0d", want.we, res.write_enable);
						mismatches++;
					end
					if (res.new_pixel !== want.pix) begin
						$error("new_pixel: expected %06h, got %06h", want.pix, res.new_pixel);
						mismatches++;
					end
				end
			end
			if (pix_fire || res_fire || cfg_fire)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("[shape_coverage_blend_unit] ERROR");
				$finish;
			end
		end
	end

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_SHAPE_MODE: shape.mode = shape_mode_t'(v[1:0]);
			REG_RECT_X:     shape.x = int'($signed(v[ORG_W-1:0]));
			REG_RECT_Y:     shape.y = int'($signed(v[ORG_W-1:0]));
			REG_RECT_W:     shape.w = int'(v[SIZE_W-1:0]);
			REG_RECT_H:     shape.h = int'(v[SIZE_W-1:0]);
			REG_CORNER_RAD: shape.rad = int'(v[RAD_W-1:0]);
			REG_STROKE:     shape.thick = int'(v[SIZE_W-1:0]);
			REG_FILL_COLOR: shape.fill = v;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic load_shape(shape_mode_t m, int x, int y, int w, int h, int r, int t,
			logic [FILL_W-1:0] fill);
		cfg_write(REG_SHAPE_MODE, CFG_DATA_W'(m));
		cfg_write(REG_RECT_X, CFG_DATA_W'(x));
		cfg_write(REG_RECT_Y, CFG_DATA_W'(y));
		cfg_write(REG_RECT_W, CFG_DATA_W'(w));
		cfg_write(REG_RECT_H, CFG_DATA_W'(h));
		cfg_write(REG_CORNER_RAD, CFG_DATA_W'(r));
		cfg_write(REG_STROKE, CFG_DATA_W'(t));
		cfg_write(REG_FILL_COLOR, fill);
	endtask

	task automatic push_pixel(int x, int y, logic [COLOR_W-1:0] d);
		pix_item_t p;
		p.x = x[PIX_COORD_W-1:0];
		p.y = y[PIX_COORD_W-1:0];
		p.dest = d;
		pixel_queue.push_back(p);
	endtask

	task automatic drain();
		while (pixel_queue.size() != 0 || expected_writes.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_shape(int k);
		shape_mode_t       m;
		int                x;
		int                y;
		int                w;
		int                h;
		int                r;
		int                t;
		int                lim;
		logic [7:0]        alpha;
		logic [FILL_W-1:0] fill;
		m = shape_mode_t'($urandom_range(3, 0));
		x = ($urandom_range(7, 0) == 0) ? int'($urandom_range(8191, 0)) - 4096
			: int'($urandom_range(1040, 0)) - 20;
		y = ($urandom_range(7, 0) == 0) ? int'($urandom_range(8191, 0)) - 4096
			: int'($urandom_range(1040, 0)) - 20;
		w = ($urandom_range(9, 0) == 0) ? $urandom_range(4095, 0) : $urandom_range(64, 0);
		h = ($urandom_range(9, 0) == 0) ? $urandom_range(4095, 0) : $urandom_range(64, 0);
		lim = ((w < h) ? w : h) / 2;
		if (m == MODE_CIRCLE)
			r = ($urandom_range(7, 0) == 0) ? $urandom_range(2047, 0) : $urandom_range(48, 0);
		else
			r = ($urandom_range(7, 0) == 0) ? $urandom_range(2047, 0) : $urandom_range(lim + 2, 0);
		t = ($urandom_range(7, 0) == 0) ? $urandom_range(4095, 0) : $urandom_range(lim + 2, 0);
		case ($urandom_range(9, 0))
			0: alpha = 8'h00;
			1, 2, 3: alpha = 8'hFF;
			default: alpha = 8'($urandom());
		endcase
		fill = {alpha, 24'($urandom())};
		if (k == 0) begin
			x = -4096;
			y = -4096;
			w = 4095;
			h = 4095;
			r = 2047;
			t = 4095;
			fill = 32'hFFFF_FFFF;
		end else if (k == 1) begin
			x = 4095;
			y = 4095;
		end else if (k == 2) begin
			x = 0;
			y = 0;
			w = 4095;
			h = 4095;
			r = 2047;
			t = 1;
			fill = {8'h01, 24'($urandom())};
		end
		load_shape(m, x, y, w, h, r, t, fill);
	endtask

	task automatic add_random_pixels(int n);
		int x0;
		int x1;
		int y0;
		int y1;
		int kind;
		int x;
		int y;
		if (shape.mode == MODE_CIRCLE) begin
			x0 = shape.x - shape.rad - 2;
			x1 = shape.x + shape.rad + 2;
			y0 = shape.y - shape.rad - 2;
			y1 = shape.y + shape.rad + 2;
		end else begin
			x0 = shape.x - 2;
			x1 = shape.x + shape.w + 2;
			y0 = shape.y - 2;
			y1 = shape.y + shape.h + 2;
		end
		x0 = (x0 < 0) ? 0 : x0;
		y0 = (y0 < 0) ? 0 : y0;
		x1 = (x1 > 4095) ? 4095 : x1;
		y1 = (y1 > 4095) ? 4095 : y1;
		repeat (n) begin
			kind = $urandom_range(9, 0);
			if (kind < 7 && x1 >= x0 && y1 >= y0) begin
				x = $urandom_range(x1, x0);
				y = $urandom_range(y1, y0);
			end else if (kind < 9) begin
				x = $urandom_range(FRAME_W - 1, 0);
				y = $urandom_range(FRAME_H - 1, 0);
			end else begin
				x = $urandom_range(4095, 0);
				y = $urandom_range(4095, 0);
			end
			push_pixel(x, y, COLOR_W'($urandom()));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_SHAPE_MODE;
		cfg.data = '0;
		shape.mode = MODE_RECT;
		shape.x = 0;
		shape.y = 0;
		shape.w = 0;
		shape.h = 0;
		shape.rad = 0;
		shape.thick = 0;
		shape.fill = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The reset configuration is an empty rectangle.
		push_pixel(0, 0, 24'h000000);
		push_pixel(4095, 4095, 24'hFFFFFF);
		drain();

		load_shape(MODE_RECT, 10, 20, 30, 40, 0, 0, 32'hFF12_3456);
		push_pixel(10, 20, 24'h000000);
		push_pixel(39, 59, 24'hABCDEF);
		push_pixel(40, 59, 24'h000000);
		push_pixel(9, 20, 24'h000000);
		drain();

		// A rectangle larger than the frame checks the frame edges.
		load_shape(MODE_RECT, 0, 0, 4095, 4095, 0, 0, 32'h80FF_00FF);
		push_pixel(1023, 1023, 24'h5A5AA5);
		push_pixel(1024, 0, 24'h000000);
		push_pixel(0, 1024, 24'h000000);
		push_pixel(0, 0, 24'hFFFFFF);
		drain();

		load_shape(MODE_RECT, 0, 0, 4095, 4095, 0, 0, 32'h00FF_FFFF);
		push_pixel(5, 5, 24'h123456);
		drain();

		// An oversized radius is clamped to half the shorter side.
		load_shape(MODE_ROUND, 100, 100, 20, 20, 2047, 0, 32'hFE80_4020);
		push_pixel(100, 100, 24'h102030);
		push_pixel(110, 100, 24'hF0E0D0);
		push_pixel(119, 119, 24'h000000);
		push_pixel(116, 116, 24'hFFFFFF);
		drain();

		// A stroke as thick as the shape falls back to a filled rounded box.
		load_shape(MODE_STROKE, 0, 0, 20, 30, 5, 4095, 32'hFF00_FF00);
		push_pixel(10, 10, 24'h000000);
		drain();

		load_shape(MODE_STROKE, 0, 0, 20, 30, 5, 0, 32'hFF00_FF00);
		push_pixel(10, 10, 24'h000000);
		push_pixel(0, 15, 24'h000000);
		drain();

		load_shape(MODE_CIRCLE, 500, 500, 0, 0, 0, 0, 32'hFFFF_FFFF);
		push_pixel(500, 500, 24'h000000);
		drain();

		load_shape(MODE_CIRCLE, 0, 0, 0, 0, 2047, 0, 32'h7F33_CC66);
		push_pixel(1023, 1023, 24'hC0FFEE);
		push_pixel(0, 0, 24'h000000);
		drain();

		for (int k = 0; k < PHASES; k++) begin
			if (k >= PHASES - 3)
				quiet = 1'b1;
			src_idle_pct = idle_pick();
			sink_stall_pct = idle_pick();
			random_shape(k);
			add_random_pixels(PHASE_ITEMS);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[shape_coverage_blend_unit] OK");
		else
			$display("[shape_coverage_blend_unit] ERROR");
		$finish;
	end

endmodule
